// ===== rtl/cks_pkg.sv =====
// Shared types, constants and the ChaCha quarter-round for the keystream block.
package cks_pkg;

  // Constant words spelling "expand 32-byte k".
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  // Quarter-round rotation amounts.
  localparam int ROT_A = 16;
  localparam int ROT_B = 12;
  localparam int ROT_C = 8;
  localparam int ROT_D = 7;

  localparam int BLOCK_BYTES = 64;
  localparam int WORD_BYTES  = 8;
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI = 3'd5;

  typedef logic [15:0][31:0] words_t;
  typedef logic [3:0][63:0]  key_t;

  // One queued block request.
  typedef struct packed {
    logic [31:0] counter;
    logic [3:0]  words;
    logic [3:0]  last_valid;
  } desc_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_t;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
    rol32 = (v << s) | (v >> (32 - s));
  endfunction

  function automatic qr_t quarter_round(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    logic [31:0] ta, tb, tc, td;
    ta = a + b;   td = rol32(d ^ ta, ROT_A);
    tc = c + td;  tb = rol32(b ^ tc, ROT_B);
    ta = ta + tb; td = rol32(td ^ ta, ROT_C);
    tc = tc + td; tb = rol32(tb ^ tc, ROT_D);
    quarter_round = '{a: ta, b: tb, c: tc, d: td};
  endfunction

endpackage

// ===== rtl/chacha8_keystream_block.sv =====
// Top level of the ChaCha keystream generator with 96-bit nonce and 32-bit counter.
//
// Each request asks for one 64-byte ChaCha block (DOUBLE_ROUNDS double rounds, eight
// rounds by default) built from the key and nonce registers and the internal block
// counter. A set restart flag returns the counter to zero before the block is made.
// The block leaves as little-endian 64-bit words, byte 8k in bits 7:0 of word k, and
// only as many words as bytes_wanted needs are sent; the last word carries
// last_of_block and its count of wanted bytes in valid_bytes, while unwanted bytes of
// that word still hold keystream. Requests above 64 bytes are treated as 64. A request
// for no bytes produces no result and leaves the counter alone, apart from a restart.
// The counter advances once per block and wraps at 2^32. Requests enter through a
// two-entry queue, so push is refused only when that queue is full. The core performs
// one round of four quarter-rounds per cycle; after the last round a done state hands the
// summed block to the result buffer once that buffer is free, and the next block is
// computed while the previous one is being popped. A request passes the queue, the
// core's round states and the done state before its first word is on the result ports.
// Configuration registers are written through cfg_write, cfg_index and cfg_data; the
// user must write them only while the block is idle, which the block does not enforce;
// indexes beyond the register list are ignored, and for the upper nonce register only
// the low 32 data bits are kept.
module chacha8_keystream_block #(
  parameter int DOUBLE_ROUNDS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [cks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic                           restart,
  input  logic [6:0]                     bytes_wanted,
  output logic                           empty,
  input  logic                           pop,
  output logic [63:0]                    keystream_bytes,
  output logic [3:0]                     valid_bytes,
  output logic                           last_of_block
);

  // Key and nonce registers, all clear after reset.
  cks_pkg::key_t   key;
  logic [63:0]     nonce_lo;
  logic [31:0]     nonce_hi;

  // Front end to queue.
  logic            enq;
  cks_pkg::desc_t  enq_desc;

  // Queue to core.
  logic            q_empty;
  logic            q_pop;
  cks_pkg::desc_t  q_head;

  // Core to result buffer.
  logic            core_done;
  logic            buf_free;
  cks_pkg::words_t core_block;
  logic [3:0]      core_words;
  logic [3:0]      core_last_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      key      <= '0;
      nonce_lo <= '0;
      nonce_hi <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        cks_pkg::CFG_KEY0:     key[0]   <= cfg_data;
        cks_pkg::CFG_KEY1:     key[1]   <= cfg_data;
        cks_pkg::CFG_KEY2:     key[2]   <= cfg_data;
        cks_pkg::CFG_KEY3:     key[3]   <= cfg_data;
        cks_pkg::CFG_NONCE_LO: nonce_lo <= cfg_data;
        cks_pkg::CFG_NONCE_HI: nonce_hi <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // The front end classifies each request and claims its counter value.
  cks_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .q_full       (full),
    .restart      (restart),
    .bytes_wanted (bytes_wanted),
    .enq          (enq),
    .desc         (enq_desc)
  );

  cks_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (enq),
    .wr_data (enq_desc),
    .rd      (q_pop),
    .full    (full),
    .empty   (q_empty),
    .rd_data (q_head)
  );

  cks_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .key        (key),
    .nonce      ({nonce_hi, nonce_lo}),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .free       (buf_free),
    .done       (core_done),
    .block      (core_block),
    .words      (core_words),
    .last_valid (core_last_valid)
  );

  // The result buffer presents the oldest word of the current block.
  cks_emit u_emit (
    .clk             (clk),
    .rst             (rst),
    .done            (core_done),
    .block           (core_block),
    .words           (core_words),
    .last_valid      (core_last_valid),
    .free            (buf_free),
    .pop             (pop),
    .empty           (empty),
    .keystream_bytes (keystream_bytes),
    .valid_bytes     (valid_bytes),
    .last_of_block   (last_of_block)
  );

endmodule

// ===== rtl/cks_front.sv =====
// Request front end: owns the block counter and turns requests into queue entries.
module cks_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              q_full,
  input  logic              restart,
  input  logic [6:0]        bytes_wanted,
  output logic              enq,
  output cks_pkg::desc_t    desc
);

  logic [31:0] block_counter;
  logic [31:0] base;
  logic [6:0]  n;
  logic [6:0]  n_minus_one;
  logic [7:0]  n_round;
  logic        accept;

  assign accept      = push && !q_full;
  assign base        = restart ? 32'd0 : block_counter;
  assign n           = (bytes_wanted > 7'(cks_pkg::BLOCK_BYTES)) ?
                       7'(cks_pkg::BLOCK_BYTES) : bytes_wanted;
  assign n_minus_one = n - 7'd1;
  assign n_round     = {1'b0, n} + 8'd7;

  assign enq              = accept && (n != 7'd0);
  assign desc.counter     = base;
  assign desc.words       = n_round[6:3];
  assign desc.last_valid  = {1'b0, n_minus_one[2:0]} + 4'd1;

  // A request for no bytes still honours its restart flag but uses no counter value.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
    end else if (accept) begin
      block_counter <= (n == 7'd0) ? base : base + 32'd1;
    end
  end

endmodule

// ===== rtl/cks_fifo.sv =====
// Short request queue between the front end and the ChaCha core.
module cks_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  cks_pkg::desc_t    wr_data,
  input  logic              rd,
  output logic              full,
  output logic              empty,
  output cks_pkg::desc_t    rd_data
);

  localparam int PTR_W = (cks_pkg::QUEUE_DEPTH > 1) ? $clog2(cks_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(cks_pkg::QUEUE_DEPTH + 1);

  cks_pkg::desc_t   mem [cks_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(cks_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(cks_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(cks_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(cks_pkg::QUEUE_DEPTH))
    else $error("request queue holds more entries than its depth");

endmodule

// ===== rtl/cks_core.sv =====
// ChaCha permutation core: one round of four quarter-rounds per cycle.
module cks_core #(
  parameter int DOUBLE_ROUNDS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  cks_pkg::key_t       key,
  input  logic [95:0]         nonce,
  input  logic                q_empty,
  input  cks_pkg::desc_t      q_head,
  output logic                q_pop,
  input  logic                free,
  output logic                done,
  output cks_pkg::words_t     block,
  output logic [3:0]          words,
  output logic [3:0]          last_valid
);

  localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
  localparam int RW     = $clog2(ROUNDS);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t          state;
  logic [RW-1:0]   rnd;
  cks_pkg::words_t x;
  cks_pkg::desc_t  cur;
  cks_pkg::words_t init_cur;
  cks_pkg::words_t init_next;
  cks_pkg::words_t col_out;
  cks_pkg::words_t diag_out;

  function automatic cks_pkg::words_t make_init(input logic [31:0] counter,
                                                input cks_pkg::key_t k,
                                                input logic [95:0] nn);
    cks_pkg::words_t w;
    w[0] = cks_pkg::SIGMA0;
    w[1] = cks_pkg::SIGMA1;
    w[2] = cks_pkg::SIGMA2;
    w[3] = cks_pkg::SIGMA3;
    for (int i = 0; i < 4; i++) begin
      w[4 + 2 * i] = k[i][31:0];
      w[5 + 2 * i] = k[i][63:32];
    end
    w[12] = counter;
    w[13] = nn[31:0];
    w[14] = nn[63:32];
    w[15] = nn[95:64];
    make_init = w;
  endfunction

  function automatic cks_pkg::words_t column_round(input cks_pkg::words_t w);
    cks_pkg::words_t r;
    cks_pkg::qr_t q;
    r = w;
    for (int i = 0; i < 4; i++) begin
      q = cks_pkg::quarter_round(w[i], w[4 + i], w[8 + i], w[12 + i]);
      r[i] = q.a; r[4 + i] = q.b; r[8 + i] = q.c; r[12 + i] = q.d;
    end
    column_round = r;
  endfunction

  function automatic cks_pkg::words_t diagonal_round(input cks_pkg::words_t w);
    cks_pkg::words_t r;
    cks_pkg::qr_t q;
    r = w;
    for (int i = 0; i < 4; i++) begin
      q = cks_pkg::quarter_round(w[i], w[4 + ((i + 1) % 4)], w[8 + ((i + 2) % 4)],
                                 w[12 + ((i + 3) % 4)]);
      r[i] = q.a;
      r[4 + ((i + 1) % 4)]  = q.b;
      r[8 + ((i + 2) % 4)]  = q.c;
      r[12 + ((i + 3) % 4)] = q.d;
    end
    diagonal_round = r;
  endfunction

  assign init_cur  = make_init(cur.counter, key, nonce);
  assign init_next = make_init(q_head.counter, key, nonce);
  assign col_out   = column_round(x);
  assign diag_out  = diagonal_round(x);

  assign done       = (state == ST_DONE);
  assign words      = cur.words;
  assign last_valid = cur.last_valid;
  assign q_pop      = !q_empty && ((state == ST_IDLE) || ((state == ST_DONE) && free));

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      block[i] = x[i] + init_cur[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rnd   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            state <= ST_RUN;
            rnd   <= '0;
          end
        end
        ST_RUN: begin
          if (rnd == RW'(ROUNDS - 1)) begin
            state <= ST_DONE;
          end else begin
            rnd <= rnd + 1'b1;
          end
        end
        ST_DONE: begin
          if (free) begin
            state <= q_pop ? ST_RUN : ST_IDLE;
            rnd   <= '0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x   <= init_next;
      cur <= q_head;
    end else if (state == ST_RUN) begin
      x <= rnd[0] ? diag_out : col_out;
    end
  end

endmodule

// ===== rtl/cks_emit.sv =====
// Result buffer that streams a finished block out as 64-bit words.
module cks_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              done,
  input  cks_pkg::words_t   block,
  input  logic [3:0]        words,
  input  logic [3:0]        last_valid,
  output logic              free,
  input  logic              pop,
  output logic              empty,
  output logic [63:0]       keystream_bytes,
  output logic [3:0]        valid_bytes,
  output logic              last_of_block
);

  cks_pkg::words_t blk;
  logic [3:0]      rem;
  logic [3:0]      lastv;
  logic            busy;
  logic            take;
  logic            load;

  assign take  = pop && busy;
  assign free  = !busy || (take && (rem == 4'd1));
  assign load  = done && free;
  assign empty = !busy;

  assign keystream_bytes = {blk[1], blk[0]};
  assign last_of_block   = (rem == 4'd1);
  assign valid_bytes     = last_of_block ? lastv : 4'(cks_pkg::WORD_BYTES);

  always_ff @(posedge clk) begin
    if (load) begin
      blk   <= block;
      lastv <= last_valid;
    end else if (take) begin
      for (int i = 0; i < 14; i++) begin
        blk[i] <= blk[i + 2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rem  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      rem  <= words;
    end else if (take) begin
      rem <= rem - 4'd1;
      if (rem == 4'd1) begin
        busy <= 1'b0;
      end
    end
  end

  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (valid_bytes != 4'd0) && (valid_bytes <= 4'd8))
    else $error("valid byte count out of range");

  a_full_words: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last_of_block) |-> (valid_bytes == 4'd8))
    else $error("a word before the last one is not full");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> !empty && (rem != 4'd0))
    else $error("loaded block did not appear at the result side");

endmodule
